/* hdl/tlg_pkg.sv */
// shared types, constants and register codes for the thermal level governor
// no dependencies; imported by every module of the block
package tlg_pkg;

  localparam int unsigned TEMP_W     = 9;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [DUTY_W-1:0]        duty_t;

  typedef enum logic [1:0] {
    LVL_NORMAL = 2'd0,
    LVL_WARM   = 2'd1,
    LVL_HOT    = 2'd2,
    LVL_CRIT   = 2'd3
  } level_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARM_ENTER   = 3'd0,
    REG_WARM_EXIT    = 3'd1,
    REG_HOT_ENTER    = 3'd2,
    REG_HOT_EXIT     = 3'd3,
    REG_CRIT_ENTER   = 3'd4,
    REG_CRIT_EXIT    = 3'd5,
    REG_FAN_FULL     = 3'd6,
    REG_FAN_RECOVER  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    temp_t warm_enter;
    temp_t warm_exit;
    temp_t hot_enter;
    temp_t hot_exit;
    temp_t crit_enter;
    temp_t crit_exit;
    duty_t fan_full;
    duty_t fan_recover;
  } cfg_t;

  typedef struct packed {
    level_e level;
    logic   fan_write;
    duty_t  fan_duty;
  } result_t;

  localparam temp_t WARM_ENTER_RST  = 9'sd48;
  localparam temp_t WARM_EXIT_RST   = 9'sd47;
  localparam temp_t HOT_ENTER_RST   = 9'sd51;
  localparam temp_t HOT_EXIT_RST    = 9'sd49;
  localparam temp_t CRIT_ENTER_RST  = 9'sd55;
  localparam temp_t CRIT_EXIT_RST   = 9'sd54;
  localparam duty_t FAN_FULL_RST    = 8'd255;
  localparam duty_t FAN_RECOVER_RST = 8'd125;
  localparam temp_t HELD_TEMP_RST   = 9'sd70;

endpackage

/* hdl/tlg_cfg_regs.sv */
// configuration register file: thresholds and fan duties
// depends on tlg_pkg
module tlg_cfg_regs import tlg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_WARM_ENTER:  cfg_d.warm_enter  = temp_t'(cfg_wdata_i);
        REG_WARM_EXIT:   cfg_d.warm_exit   = temp_t'(cfg_wdata_i);
        REG_HOT_ENTER:   cfg_d.hot_enter   = temp_t'(cfg_wdata_i);
        REG_HOT_EXIT:    cfg_d.hot_exit    = temp_t'(cfg_wdata_i);
        REG_CRIT_ENTER:  cfg_d.crit_enter  = temp_t'(cfg_wdata_i);
        REG_CRIT_EXIT:   cfg_d.crit_exit   = temp_t'(cfg_wdata_i);
        REG_FAN_FULL:    cfg_d.fan_full    = cfg_wdata_i[DUTY_W-1:0];
        REG_FAN_RECOVER: cfg_d.fan_recover = cfg_wdata_i[DUTY_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warm_enter  <= WARM_ENTER_RST;
      cfg_q.warm_exit   <= WARM_EXIT_RST;
      cfg_q.hot_enter   <= HOT_ENTER_RST;
      cfg_q.hot_exit    <= HOT_EXIT_RST;
      cfg_q.crit_enter  <= CRIT_ENTER_RST;
      cfg_q.crit_exit   <= CRIT_EXIT_RST;
      cfg_q.fan_full    <= FAN_FULL_RST;
      cfg_q.fan_recover <= FAN_RECOVER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/tlg_level_fsm.sv */
// level state machine with hysteresis, held temperature and fan write decode
// depends on tlg_pkg
module tlg_level_fsm import tlg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    sample_ok_i,
  input  temp_t   sample_temp_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  level_e level_q, level_d;
  temp_t  held_q, held_d;
  temp_t  temp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LVL_NORMAL;
      held_q  <= HELD_TEMP_RST;
    end else if (step_i) begin
      level_q <= level_d;
      held_q  <= held_d;
    end
  end

  always_comb begin
    // a failed read falls back to the last good temperature
    held_d = sample_ok_i ? sample_temp_i : held_q;
    temp   = held_d;
    level_d = level_q;
    case (level_q)
      LVL_NORMAL: begin
        if ($signed(temp) >= $signed(cfg_i.warm_enter)) level_d = LVL_WARM;
      end
      LVL_WARM: begin
        // stepping up wins over stepping down
        if ($signed(temp) >= $signed(cfg_i.hot_enter))     level_d = LVL_HOT;
        else if ($signed(temp) < $signed(cfg_i.warm_exit)) level_d = LVL_NORMAL;
      end
      LVL_HOT: begin
        if ($signed(temp) >= $signed(cfg_i.crit_enter))   level_d = LVL_CRIT;
        else if ($signed(temp) < $signed(cfg_i.hot_exit)) level_d = LVL_WARM;
      end
      LVL_CRIT: begin
        if ($signed(temp) < $signed(cfg_i.crit_exit)) level_d = LVL_HOT;
      end
      default: level_d = LVL_NORMAL;
    endcase

    result_o.level     = level_d;
    result_o.fan_write = 1'b0;
    result_o.fan_duty  = '0;
    if (level_d == LVL_CRIT && level_q != LVL_CRIT) begin
      result_o.fan_write = 1'b1;
      result_o.fan_duty  = cfg_i.fan_full;
    end else if (level_q == LVL_CRIT && level_d != LVL_CRIT) begin
      result_o.fan_write = 1'b1;
      result_o.fan_duty  = cfg_i.fan_recover;
    end
  end

  a_fan_on_crit_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.fan_write |=> (level_q == LVL_CRIT) != $past(level_q == LVL_CRIT))
    else $error("fan write without a critical transition");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(level_q) && $stable(held_q))
    else $error("state changed without a step");

  a_one_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> ($past(level_q) == level_q)
            || ({1'b0, $past(level_q)} + 3'd1 == {1'b0, level_q})
            || ({1'b0, level_q} + 3'd1 == {1'b0, $past(level_q)}))
    else $error("level moved more than one step");

endmodule

/* hdl/thermal_level_governor.sv */
// thermal level governor: a reading passes the input register, then the result
// register; throughput one reading per cycle unless the result is stalled by
// out_ready_i low, the input register refills while the result register drains
// state logic between the two registers is a few 9-bit compares and a mux
// reset: level normal, held temperature 70, registers at their defaults, no item held
// depends on tlg_pkg, tlg_cfg_regs, tlg_level_fsm
module thermal_level_governor import tlg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  sample_ok_i,
  input  logic signed [8:0]     sample_temp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            level_o,
  output logic                  fan_write_o,
  output logic [7:0]            fan_duty_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  result_t result;

  logic    in_vld_q;
  logic    ok_q;
  temp_t   temp_q;
  logic    out_vld_q;
  result_t res_q;
  logic    adv;

  tlg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // item moves into the result register when that register is free or draining
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  tlg_level_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (adv),
    .sample_ok_i   (ok_q),
    .sample_temp_i (temp_q),
    .cfg_i         (cfg),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (adv) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ok_q   <= sample_ok_i;
      temp_q <= sample_temp_i;
    end
    if (adv) res_q <= result;
  end

  assign out_valid_o = out_vld_q;
  assign level_o     = res_q.level;
  assign fan_write_o = res_q.fan_write;
  assign fan_duty_o  = res_q.fan_duty;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fan_write_o |-> fan_duty_o == '0)
    else $error("fan duty nonzero without a fan write");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("stepped item did not reach the result register");

endmodule
